[rtl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

    localparam int WORD_BITS = 32;
    localparam int POS_W     = 5;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_ALREADY = 2'd3
    } status_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } scan_res_t;

endpackage

[rtl/bba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/bba_scan.sv]
// Find-first-zero unit over one map word, with padding bits forced used.
module bba_scan (
    input  logic [31:0]       word,
    input  logic [31:0]       pad,
    output bba_pkg::scan_res_t res
);

    import bba_pkg::*;

    logic [WORD_BITS-1:0] busy;

    always_comb
    begin
        busy    = word | pad;
        res.hit = ~&busy;
        res.pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!busy[i])
            begin
                res.pos = POS_W'(i);
            end
        end
    end

endmodule

[rtl/bitmap_block_allocator_top.sv]
// Top level of the first-fit bitmap block allocator.
//
// Channel | Dir | Signals                       | Contents
// s_      | in  | s_tvalid s_tready s_tdata      | block_index; s_tuser = command
// m_      | out | m_tvalid m_tready m_tdata      | granted_block, free_count; m_tuser = status
//
// After reset a clearing pass writes every map word before s_tready rises.
// Allocate: one map word checked per cycle in the RAM read pipeline.
// Free: one RAM read, then one read-modify-write; an out-of-range free goes straight to the result.
// One request in flight; a finished result waits in the output register while the next
// request is taken, and the sequencer holds in its result state if that register is full.
module bitmap_block_allocator_top #(
    parameter int BLOCK_COUNT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] block_index
    input  logic [0:0]       s_tuser,   // [0] command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [9:0] granted_block, [20:10] free_count, zero fill
    output bba_pkg::status_t m_tuser    // [1:0] status
);

    import bba_pkg::*;

    localparam int MAP_WORDS = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(BLOCK_COUNT + 1);
    localparam int TAIL      = BLOCK_COUNT % WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_PAD =
        (TAIL == 0) ? '0 : ~((32'd1 << TAIL) - 32'd1);
    localparam logic [WORD_AW-1:0] LAST_W  = WORD_AW'(MAP_WORDS - 1);
    localparam logic [WORD_AW-1:0] FIRST_P = (MAP_WORDS > 1) ? WORD_AW'(1) : '0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [WORD_AW-1:0]   ptr_reg;
    logic [WORD_AW-1:0]   chk_reg;
    logic [POS_W-1:0]     bit_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [9:0]           res_granted_reg;
    status_t              res_status_reg;
    logic                 out_valid_reg;
    logic [9:0]           out_granted_reg;
    status_t              out_status_reg;
    logic [10:0]          out_cnt_reg;

    logic                 cmd_free;
    logic [10:0]          in_word;
    logic                 in_range;
    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] pad;
    scan_res_t            scan;
    logic [31:0]          idx32;
    logic [31:0]          cnt32;
    logic                 bit_used;

    assign cmd_free = s_tuser[0];
    assign in_word  = s_tdata[15:5];
    assign in_range = {1'b0, s_tdata} < 17'(BLOCK_COUNT);
    assign pad      = (chk_reg == LAST_W) ? LAST_PAD : '0;
    assign idx32    = 32'({chk_reg, scan.pos});
    assign cnt32    = 32'(cnt_reg);
    assign bit_used = ram_rdata[bit_reg];

    bba_scan u_scan (
        .word (ram_rdata),
        .pad  (pad),
        .res  (scan)
    );

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WORD_AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_reg;
        ram_wdata = '0;
        ram_raddr = ptr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
            end
            S_IDLE:
            begin
                ram_raddr = cmd_free ? in_word[WORD_AW-1:0] : '0;
            end
            S_SCAN:
            begin
                ram_we    = scan.hit;
                ram_wdata = ram_rdata | (32'd1 << scan.pos);
            end
            S_FREE:
            begin
                ram_we    = bit_used;
                ram_wdata = ram_rdata & ~(32'd1 << bit_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            ptr_reg         <= '0;
            chk_reg         <= '0;
            bit_reg         <= '0;
            cnt_reg         <= CNT_W'(BLOCK_COUNT);
            res_granted_reg <= '0;
            res_status_reg  <= STAT_OK;
            out_valid_reg   <= 1'b0;
            out_granted_reg <= '0;
            out_status_reg  <= STAT_OK;
            out_cnt_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (ptr_reg == LAST_W)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + WORD_AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        res_granted_reg <= '0;
                        chk_reg         <= cmd_free ? in_word[WORD_AW-1:0] : '0;
                        bit_reg         <= s_tdata[4:0];
                        if (!cmd_free)
                        begin
                            ptr_reg   <= FIRST_P;
                            state_reg <= S_SCAN;
                        end
                        else if (!in_range)
                        begin
                            res_status_reg <= STAT_RANGE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_FREE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan.hit)
                    begin
                        res_granted_reg <= idx32[9:0];
                        res_status_reg  <= STAT_OK;
                        cnt_reg         <= cnt_reg - CNT_W'(1);
                        state_reg       <= S_DONE;
                    end
                    else if (chk_reg == LAST_W)
                    begin
                        res_status_reg <= STAT_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        chk_reg <= chk_reg + WORD_AW'(1);
                        if (ptr_reg != LAST_W)
                        begin
                            ptr_reg <= ptr_reg + WORD_AW'(1);
                        end
                    end
                end
                S_FREE:
                begin
                    if (bit_used)
                    begin
                        res_status_reg <= STAT_OK;
                        cnt_reg        <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_status_reg <= STAT_ALREADY;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_granted_reg <= res_granted_reg;
                        out_status_reg  <= res_status_reg;
                        out_cnt_reg     <= cnt32[10:0];
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_cnt_reg, out_granted_reg};
    assign m_tuser  = out_status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(BLOCK_COUNT))
        else $error("free count above pool size");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_FULL |-> m_tdata[20:10] == 11'd0)
        else $error("full status with nonzero free count");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[9:0] == 10'd0)
        else $error("granted block set on failed request");

endmodule
